FILE: src/ifp_pkg.sv
package ifp_pkg;

    // Default for the frame buffer depth of the top level.
    localparam int BUFFER_DEPTH_DEF = 32;

    // Known frames always close after this many bytes.
    localparam int FRAME_LENGTH = 11;

    // Byte positions of the three little-endian words inside a frame.
    localparam int RAW_FIRST = 2;
    localparam int RAW_LAST  = 7;

    // Result field widths.
    localparam int RATE_W = 23;
    localparam int YAW_W  = 22;

    // Frame bytes with a meaning of their own.
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_YAW    = 8'h53;

    // Scale factors that turn a raw word into the fixed-point result.
    localparam logic signed [RATE_W-1:0] RATE_SCALE = RATE_W'(125);
    localparam logic signed [YAW_W-1:0]  YAW_SCALE  = YAW_W'(45);

    typedef logic [1:0] status_t;

    localparam status_t ST_RATE = 2'd0;
    localparam status_t ST_YAW  = 2'd1;
    localparam status_t ST_CSUM = 2'd2;
    localparam status_t ST_DROP = 2'd3;

    typedef logic signed [15:0] raw_t;

    // One closed frame as handed to the scaling logic.
    typedef struct packed {
        status_t status;
        raw_t    raw_x;
        raw_t    raw_y;
        raw_t    raw_z;
    } frame_t;

endpackage

FILE: src/ifp_scale.sv
module ifp_scale
    import ifp_pkg::*;
(
    input  frame_t                    frame,
    output logic signed [RATE_W-1:0]  rate_x,
    output logic signed [RATE_W-1:0]  rate_y,
    output logic signed [RATE_W-1:0]  rate_z,
    output logic signed [YAW_W-1:0]   yaw_angle
);

    // Sign-extended raw words.
    logic signed [RATE_W-1:0] ext_x;
    logic signed [RATE_W-1:0] ext_y;
    logic signed [RATE_W-1:0] ext_z;
    logic signed [YAW_W-1:0]  ext_yaw;

    assign ext_x   = RATE_W'(frame.raw_x);
    assign ext_y   = RATE_W'(frame.raw_y);
    assign ext_z   = RATE_W'(frame.raw_z);
    assign ext_yaw = YAW_W'(frame.raw_z);

    // Constant multiplies; fields the status does not use read as zero.
    always_comb
    begin
        rate_x    = '0;
        rate_y    = '0;
        rate_z    = '0;
        yaw_angle = '0;
        unique case (frame.status)
            ST_RATE:
            begin
                rate_x = ext_x * RATE_SCALE;
                rate_y = ext_y * RATE_SCALE;
                rate_z = ext_z * RATE_SCALE;
            end
            ST_YAW:
            begin
                yaw_angle = ext_yaw * YAW_SCALE;
            end
            default:
            begin
                rate_x    = '0;
                rate_y    = '0;
                rate_z    = '0;
                yaw_angle = '0;
            end
        endcase
    end

endmodule

FILE: src/imu_frame_parser.sv
// Serial frame parser for inertial sensor telemetry. It takes one received
// byte per beat and accepts a byte in every clock cycle while byte_stall is
// low. A 0x55 byte opens a frame; rate (0x52) and yaw (0x53) frames close on
// their eleventh byte and give one result beat in the cycle after, holding
// the scaled rates or yaw, or a checksum error status. Frames of any other
// type are dropped with an overflow status once BUFFER_DEPTH bytes are held.
// The checksum is kept as a running sum, and only the type byte and the six
// data bytes of a frame are stored. A result sits in an output register;
// byte_stall rises only while that register is held by result_stall and the
// next byte could close a frame, so bytes keep flowing in while a result waits.
module imu_frame_parser
    import ifp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      byte_valid,
    output logic                      byte_stall,
    input  logic [7:0]                rx_byte,
    output logic                      result_valid,
    input  logic                      result_stall,
    output status_t                   status,
    output logic signed [RATE_W-1:0]  rate_x,
    output logic signed [RATE_W-1:0]  rate_y,
    output logic signed [RATE_W-1:0]  rate_z,
    output logic signed [YAW_W-1:0]   yaw_angle
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_LENGTH - 1);
    localparam logic [CW-1:0] LAST_BUF = CW'(BUFFER_DEPTH - 1);
    localparam logic [CW-1:0] TYPE_IDX = CW'(1);

    logic              in_frame_reg;
    logic [CW-1:0]     count_reg;
    logic [7:0]        type_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        data_reg [RAW_FIRST:RAW_LAST];
    logic              result_valid_reg;
    status_t           status_reg;
    logic signed [RATE_W-1:0] rate_x_reg;
    logic signed [RATE_W-1:0] rate_y_reg;
    logic signed [RATE_W-1:0] rate_z_reg;
    logic signed [YAW_W-1:0]  yaw_reg;

    logic              accept;
    logic              known_type;
    logic              close_known;
    logic              drop;
    logic              emit;
    logic              may_close;
    frame_t            frame;
    logic signed [RATE_W-1:0] scaled_x;
    logic signed [RATE_W-1:0] scaled_y;
    logic signed [RATE_W-1:0] scaled_z;
    logic signed [YAW_W-1:0]  scaled_yaw;

    // Stall only when a result is held and this beat could produce another.
    assign may_close  = in_frame_reg && (count_reg == LAST_IDX || count_reg == LAST_BUF);
    assign byte_stall = result_valid_reg && result_stall && may_close;
    assign accept     = byte_valid && !byte_stall;

    // Frame closing decisions for the incoming byte.
    assign known_type  = (type_reg == TYPE_RATE) || (type_reg == TYPE_YAW);
    assign close_known = in_frame_reg && (count_reg == LAST_IDX) && known_type;
    assign drop        = in_frame_reg && !close_known && (count_reg == LAST_BUF);
    assign emit        = accept && (close_known || drop);

    // Status of the closing frame and its raw words.
    always_comb
    begin
        priority if (drop)
            frame.status = ST_DROP;
        else if (rx_byte != sum_reg)
            frame.status = ST_CSUM;
        else if (type_reg == TYPE_RATE)
            frame.status = ST_RATE;
        else
            frame.status = ST_YAW;
        frame.raw_x = {data_reg[3], data_reg[2]};
        frame.raw_y = {data_reg[5], data_reg[4]};
        frame.raw_z = {data_reg[7], data_reg[6]};
    end

    ifp_scale u_scale (
        .frame     (frame),
        .rate_x    (scaled_x),
        .rate_y    (scaled_y),
        .rate_z    (scaled_z),
        .yaw_angle (scaled_yaw)
    );

    // Frame tracking and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!in_frame_reg)
                begin
                    if (rx_byte == HEADER_BYTE)
                    begin
                        in_frame_reg <= 1'b1;
                        count_reg    <= CW'(1);
                    end
                end
                else if (close_known)
                begin
                    in_frame_reg <= 1'b0;
                    count_reg    <= count_reg + CW'(1);
                end
                else if (drop)
                begin
                    in_frame_reg <= 1'b0;
                    count_reg    <= '0;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            if (emit)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Frame contents: type byte, running checksum and the data bytes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                sum_reg <= HEADER_BYTE;
            end
            else
            begin
                sum_reg <= sum_reg + rx_byte;
                if (count_reg == TYPE_IDX)
                    type_reg <= rx_byte;
                for (int i = RAW_FIRST; i <= RAW_LAST; i++)
                begin
                    if (count_reg == CW'(i))
                        data_reg[i] <= rx_byte;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= frame.status;
            rate_x_reg <= scaled_x;
            rate_y_reg <= scaled_y;
            rate_z_reg <= scaled_z;
            yaw_reg    <= scaled_yaw;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign rate_x       = rate_x_reg;
    assign rate_y       = rate_y_reg;
    assign rate_z       = rate_z_reg;
    assign yaw_angle    = yaw_reg;

    // The input is held back only while a result waits at the output.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid)
        else $error("byte_stall raised with no result waiting");

    // A byte taken while idle never produces a result.
    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && !in_frame_reg && !(result_valid && result_stall))
        |=> !result_valid)
        else $error("result produced by a byte outside a frame");

    // The byte count stays below the buffer depth during a frame.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (count_reg < LAST_BUF + CW'(1)))
        else $error("byte count ran past the buffer depth");

    // A rate result carries no yaw.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == ST_RATE) |-> (yaw_angle == '0))
        else $error("rate result carries a nonzero yaw");

endmodule
